// ===== src/gwam_pkg.sv =====
// shared types, codes and constants for the graph walk block
package gwam_pkg;

   localparam int MAX_NODES_DEF = 16;
   localparam int VERTEX_W = 4;
   localparam int COUNT_W = 5;

   typedef logic [VERTEX_W-1:0] vertex_type;
   typedef logic [COUNT_W-1:0] count_type;

   typedef enum logic [1:0] {
      OP_EDGE    = 2'd0,
      OP_DEPTH   = 2'd1,
      OP_BREADTH = 2'd2,
      OP_CLEAR   = 2'd3
   } op_type;

   localparam logic STATUS_OK = 1'b0;
   localparam logic STATUS_RANGE = 1'b1;

   typedef struct packed {
      op_type     cmd;
      vertex_type first_vertex;
      vertex_type second_vertex;
   } req_data_type;

   typedef struct packed {
      vertex_type vertex;
      logic       last;
      logic       status;
   } rsp_data_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_EDGE_A,
      ST_EDGE_B,
      ST_DFS_READ,
      ST_DFS_SCAN,
      ST_DFS_POP,
      ST_BFS_FETCH,
      ST_BFS_LOAD,
      ST_BFS_SCAN
   } state_type;

   typedef enum logic [1:0] {
      ROW_CUR,
      ROW_A,
      ROW_B,
      ROW_LIST
   } row_src_type;

   typedef enum logic [2:0] {
      RSP_NONE,
      RSP_OK,
      RSP_ERR,
      RSP_STEP,
      RSP_FINAL
   } rsp_kind_type;

   typedef struct packed {
      logic         take_req;
      logic         rd_row;
      row_src_type  rd_src;
      logic         wr_row;
      logic         wr_second;
      logic         clear_graph;
      logic         walk_init;
      logic         visit;
      logic         push;
      logic         enqueue;
      logic         pop;
      logic         fetch;
      logic         load_cur;
      rsp_kind_type rsp_kind;
   } ctl_cmd_type;

   typedef struct packed {
      op_type op;
      logic   first_bad;
      logic   second_bad;
      logic   found;
      logic   stack_empty;
      logic   queue_done;
   } ctl_status_type;

endpackage

// ===== src/gwam_ctrl.sv =====
// controller state machine for the graph walk block
module gwam_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  gwam_pkg::ctl_status_type status,
   output gwam_pkg::ctl_cmd_type    cmd
);

   gwam_pkg::state_type state_ff;
   gwam_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gwam_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         gwam_pkg::ST_IDLE: begin
            if (start) begin
               state_in = gwam_pkg::ST_DISPATCH;
            end
         end
         gwam_pkg::ST_DISPATCH: begin
            case (status.op)
               gwam_pkg::OP_EDGE: begin
                  if (status.first_bad || status.second_bad) begin
                     state_in = gwam_pkg::ST_IDLE;
                  end else begin
                     state_in = gwam_pkg::ST_EDGE_A;
                  end
               end
               gwam_pkg::OP_DEPTH: begin
                  state_in = status.first_bad ? gwam_pkg::ST_IDLE : gwam_pkg::ST_DFS_READ;
               end
               gwam_pkg::OP_BREADTH: begin
                  state_in = status.first_bad ? gwam_pkg::ST_IDLE : gwam_pkg::ST_BFS_FETCH;
               end
               default: begin
                  state_in = gwam_pkg::ST_IDLE;
               end
            endcase
         end
         gwam_pkg::ST_EDGE_A: begin
            state_in = gwam_pkg::ST_EDGE_B;
         end
         gwam_pkg::ST_EDGE_B: begin
            state_in = gwam_pkg::ST_IDLE;
         end
         gwam_pkg::ST_DFS_READ: begin
            state_in = gwam_pkg::ST_DFS_SCAN;
         end
         gwam_pkg::ST_DFS_SCAN: begin
            if (status.found) begin
               state_in = gwam_pkg::ST_DFS_READ;
            end else if (status.stack_empty) begin
               state_in = gwam_pkg::ST_IDLE;
            end else begin
               state_in = gwam_pkg::ST_DFS_POP;
            end
         end
         gwam_pkg::ST_DFS_POP: begin
            state_in = gwam_pkg::ST_DFS_SCAN;
         end
         gwam_pkg::ST_BFS_FETCH: begin
            state_in = status.queue_done ? gwam_pkg::ST_IDLE : gwam_pkg::ST_BFS_LOAD;
         end
         gwam_pkg::ST_BFS_LOAD: begin
            state_in = gwam_pkg::ST_BFS_SCAN;
         end
         gwam_pkg::ST_BFS_SCAN: begin
            if (!status.found) begin
               state_in = gwam_pkg::ST_BFS_FETCH;
            end
         end
         default: begin
            state_in = gwam_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      busy = (state_ff != gwam_pkg::ST_IDLE);
      case (state_ff)
         gwam_pkg::ST_IDLE: begin
            cmd.take_req = start;
         end
         gwam_pkg::ST_DISPATCH: begin
            case (status.op)
               gwam_pkg::OP_EDGE: begin
                  if (status.first_bad || status.second_bad) begin
                     cmd.rsp_kind = gwam_pkg::RSP_ERR;
                  end else begin
                     cmd.rd_row = 1'b1;
                     cmd.rd_src = gwam_pkg::ROW_A;
                  end
               end
               gwam_pkg::OP_DEPTH, gwam_pkg::OP_BREADTH: begin
                  if (status.first_bad) begin
                     cmd.rsp_kind = gwam_pkg::RSP_ERR;
                  end else begin
                     cmd.walk_init = 1'b1;
                  end
               end
               default: begin
                  cmd.clear_graph = 1'b1;
                  cmd.rsp_kind = gwam_pkg::RSP_OK;
               end
            endcase
         end
         gwam_pkg::ST_EDGE_A: begin
            cmd.wr_row = 1'b1;
            cmd.rd_row = 1'b1;
            cmd.rd_src = gwam_pkg::ROW_B;
         end
         gwam_pkg::ST_EDGE_B: begin
            cmd.wr_row = 1'b1;
            cmd.wr_second = 1'b1;
            cmd.rsp_kind = gwam_pkg::RSP_OK;
         end
         gwam_pkg::ST_DFS_READ: begin
            cmd.rd_row = 1'b1;
            cmd.rd_src = gwam_pkg::ROW_CUR;
         end
         gwam_pkg::ST_DFS_SCAN: begin
            if (status.found) begin
               cmd.visit = 1'b1;
               cmd.push = 1'b1;
               cmd.rsp_kind = gwam_pkg::RSP_STEP;
            end else if (status.stack_empty) begin
               cmd.rsp_kind = gwam_pkg::RSP_FINAL;
            end else begin
               cmd.pop = 1'b1;
            end
         end
         gwam_pkg::ST_DFS_POP: begin
            cmd.load_cur = 1'b1;
            cmd.rd_row = 1'b1;
            cmd.rd_src = gwam_pkg::ROW_LIST;
         end
         gwam_pkg::ST_BFS_FETCH: begin
            if (status.queue_done) begin
               cmd.rsp_kind = gwam_pkg::RSP_FINAL;
            end else begin
               cmd.fetch = 1'b1;
            end
         end
         gwam_pkg::ST_BFS_LOAD: begin
            cmd.rd_row = 1'b1;
            cmd.rd_src = gwam_pkg::ROW_LIST;
         end
         gwam_pkg::ST_BFS_SCAN: begin
            if (status.found) begin
               cmd.visit = 1'b1;
               cmd.enqueue = 1'b1;
               cmd.rsp_kind = gwam_pkg::RSP_STEP;
            end
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ===== src/gwam_datapath.sv =====
// datapath: adjacency memory, visited marks, stack and queue memory, result register
module gwam_datapath #(
   parameter int MAX_NODES = gwam_pkg::MAX_NODES_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  gwam_pkg::req_data_type   req_data,
   input  logic                     csr_we,
   input  gwam_pkg::count_type      csr_wdata,
   input  gwam_pkg::ctl_cmd_type    cmd,
   output gwam_pkg::ctl_status_type status,
   output logic                     rsp_valid,
   output gwam_pkg::rsp_data_type   rsp_data
);

   localparam int VW = $clog2(MAX_NODES);
   localparam int CW = $clog2(MAX_NODES + 1);

   typedef logic [VW-1:0] idx_type;
   typedef logic [CW-1:0] ptr_type;
   typedef logic [MAX_NODES-1:0] row_type;

   row_type adj_mem [MAX_NODES];
   idx_type lst_mem [MAX_NODES];

   gwam_pkg::count_type    vcount_ff, vcount_in;
   gwam_pkg::op_type       op_cmd_ff, op_cmd_in;
   gwam_pkg::vertex_type   op_a_ff, op_a_in;
   gwam_pkg::vertex_type   op_b_ff, op_b_in;
   idx_type                cur_ff, cur_in;
   idx_type                pend_ff, pend_in;
   row_type                vis_ff, vis_in;
   row_type                row_vld_ff, row_vld_in;
   row_type                rd_row_ff;
   logic                   rd_vld_ff;
   idx_type                lst_rd_ff;
   ptr_type                ptr_ff, ptr_in;
   ptr_type                head_ff, head_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   gwam_pkg::rsp_data_type rsp_data_ff, rsp_data_in;

   ptr_type act_cnt;
   ptr_type ptr_dec;
   idx_type a_idx;
   idx_type b_idx;
   idx_type pick;
   idx_type rd_addr;
   idx_type wr_addr;
   idx_type lst_wr_addr;
   idx_type lst_wr_data;
   idx_type lst_rd_addr;
   row_type eff_row;
   row_type rng_mask;
   row_type cand;
   row_type oh_a;
   row_type oh_b;
   row_type oh_pick;
   row_type oh_wr;
   row_type wr_data;
   logic    lst_we;

   always_comb begin
      act_cnt = (int'(vcount_ff) > MAX_NODES) ? ptr_type'(MAX_NODES) : ptr_type'(vcount_ff);
      a_idx = idx_type'(op_a_ff);
      b_idx = idx_type'(op_b_ff);
      ptr_dec = ptr_ff - ptr_type'(1);
      eff_row = rd_vld_ff ? rd_row_ff : '0;
      for (int i = 0; i < MAX_NODES; i++) begin
         rng_mask[i] = (i < int'(act_cnt));
      end
      cand = eff_row & ~vis_ff & rng_mask;
      pick = '0;
      for (int i = MAX_NODES - 1; i >= 0; i--) begin
         if (cand[i]) begin
            pick = idx_type'(i);
         end
      end
      oh_a = '0;
      oh_a[a_idx] = 1'b1;
      oh_b = '0;
      oh_b[b_idx] = 1'b1;
      oh_pick = '0;
      oh_pick[pick] = 1'b1;
   end

   always_comb begin
      case (cmd.rd_src)
         gwam_pkg::ROW_CUR:  rd_addr = cur_ff;
         gwam_pkg::ROW_A:    rd_addr = a_idx;
         gwam_pkg::ROW_B:    rd_addr = b_idx;
         gwam_pkg::ROW_LIST: rd_addr = lst_rd_ff;
         default:            rd_addr = cur_ff;
      endcase
      wr_addr = cmd.wr_second ? b_idx : a_idx;
      oh_wr = cmd.wr_second ? oh_b : oh_a;
      wr_data = eff_row | (cmd.wr_second ? oh_a : oh_b);
      lst_we = cmd.walk_init || cmd.push || cmd.enqueue;
      lst_wr_addr = cmd.walk_init ? '0 : ptr_ff[VW-1:0];
      if (cmd.walk_init) begin
         lst_wr_data = a_idx;
      end else if (cmd.push) begin
         lst_wr_data = cur_ff;
      end else begin
         lst_wr_data = pick;
      end
      lst_rd_addr = cmd.pop ? ptr_dec[VW-1:0] : head_ff[VW-1:0];
   end

   always_comb begin
      vcount_in = csr_we ? csr_wdata : vcount_ff;
      op_cmd_in = op_cmd_ff;
      op_a_in = op_a_ff;
      op_b_in = op_b_ff;
      if (cmd.take_req) begin
         op_cmd_in = req_data.cmd;
         op_a_in = req_data.first_vertex;
         op_b_in = req_data.second_vertex;
      end
      row_vld_in = row_vld_ff;
      if (cmd.clear_graph) begin
         row_vld_in = '0;
      end else if (cmd.wr_row) begin
         row_vld_in = row_vld_ff | oh_wr;
      end
      vis_in = vis_ff;
      pend_in = pend_ff;
      cur_in = cur_ff;
      ptr_in = ptr_ff;
      head_in = head_ff;
      if (cmd.clear_graph) begin
         vis_in = '0;
      end
      if (cmd.walk_init) begin
         vis_in = oh_a;
         pend_in = a_idx;
         cur_in = a_idx;
         ptr_in = (op_cmd_ff == gwam_pkg::OP_BREADTH) ? ptr_type'(1) : '0;
         head_in = '0;
      end
      if (cmd.visit) begin
         vis_in = vis_ff | oh_pick;
         pend_in = pick;
      end
      if (cmd.push) begin
         cur_in = pick;
         ptr_in = ptr_ff + ptr_type'(1);
      end
      if (cmd.enqueue) begin
         ptr_in = ptr_ff + ptr_type'(1);
      end
      if (cmd.pop) begin
         ptr_in = ptr_dec;
      end
      if (cmd.fetch) begin
         head_in = head_ff + ptr_type'(1);
      end
      if (cmd.load_cur) begin
         cur_in = lst_rd_ff;
      end
   end

   always_comb begin
      rsp_valid_in = (cmd.rsp_kind != gwam_pkg::RSP_NONE);
      rsp_data_in.vertex = '0;
      rsp_data_in.last = 1'b1;
      rsp_data_in.status = gwam_pkg::STATUS_OK;
      case (cmd.rsp_kind)
         gwam_pkg::RSP_ERR: begin
            rsp_data_in.status = gwam_pkg::STATUS_RANGE;
         end
         gwam_pkg::RSP_STEP: begin
            rsp_data_in.vertex = gwam_pkg::vertex_type'(pend_ff);
            rsp_data_in.last = 1'b0;
         end
         gwam_pkg::RSP_FINAL: begin
            rsp_data_in.vertex = gwam_pkg::vertex_type'(pend_ff);
         end
         default: begin
            rsp_data_in.status = gwam_pkg::STATUS_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_row) begin
         adj_mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_row) begin
         rd_row_ff <= adj_mem[rd_addr];
         rd_vld_ff <= row_vld_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (lst_we) begin
         lst_mem[lst_wr_addr] <= lst_wr_data;
      end
      if (cmd.pop || cmd.fetch) begin
         lst_rd_ff <= lst_mem[lst_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= '0;
         row_vld_ff <= '0;
         vis_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         vcount_ff <= vcount_in;
         row_vld_ff <= row_vld_in;
         vis_ff <= vis_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_cmd_ff <= op_cmd_in;
      op_a_ff <= op_a_in;
      op_b_ff <= op_b_in;
      cur_ff <= cur_in;
      pend_ff <= pend_in;
      ptr_ff <= ptr_in;
      head_ff <= head_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      status.op = op_cmd_ff;
      status.first_bad = (int'(op_a_ff) >= int'(act_cnt));
      status.second_bad = (int'(op_b_ff) >= int'(act_cnt));
      status.found = |cand;
      status.stack_empty = (ptr_ff == '0);
      status.queue_done = (head_ff == ptr_ff);
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

endmodule

// ===== src/graph_walk_adjacency_matrix.sv =====
// top level of the graph walk block over an adjacency bit matrix
//
// request channel: a transaction is taken when start is high and busy is low; req_data
// carries the command, the first vertex and the second vertex
// result channel: rsp_valid marks each result for one cycle; the receiver cannot stall,
// so every result is taken in the cycle it appears; rsp_data.last ends a transaction
// configuration: csr_we writes csr_wdata to the vertex count; the user must write
// only while busy is low; the block itself does not enforce this
// clear, or edge or walk with a bad vertex: one result, from the dispatch state
// edge insert: one result after a read-modify-write of two rows
// depth-first walk: visits pass dfs_scan, dfs_read; backtracks pass dfs_scan, dfs_pop
// breadth-first walk: visits in bfs_scan; each dequeue passes bfs_fetch, bfs_load
// the single matrix read port and the registered stack and queue reads set the walk pace
// busy stays high until the last result of a transaction has been issued
// reset empties the graph, zeroes the vertex count and returns to idle
module graph_walk_adjacency_matrix #(
   parameter int MAX_NODES = gwam_pkg::MAX_NODES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  gwam_pkg::req_data_type req_data,
   input  logic                   csr_we,
   input  gwam_pkg::count_type    csr_wdata,
   output logic                   rsp_valid,
   output gwam_pkg::rsp_data_type rsp_data
);

   gwam_pkg::ctl_cmd_type    ctl_cmd;
   gwam_pkg::ctl_status_type ctl_status;

   gwam_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (ctl_status),
      .cmd    (ctl_cmd)
   );

   gwam_datapath #(
      .MAX_NODES (MAX_NODES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd       (ctl_cmd),
      .status    (ctl_status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== src/gwam_checker.sv =====
// port-level assertion checker for the graph walk block, with its bind
module gwam_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input gwam_pkg::req_data_type req_data,
   input logic                   csr_we,
   input gwam_pkg::count_type    csr_wdata,
   input logic                   rsp_valid,
   input gwam_pkg::rsp_data_type rsp_data
);

   a_reset_idle : assert property (@(posedge clock)
      reset |=> (!busy && !rsp_valid))
      else $error("block not idle after reset");

   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   a_last_ends : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.last == !busy))
      else $error("last flag does not match end of transaction");

   a_error_form : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status) |-> (rsp_data.last && (rsp_data.vertex == '0)))
      else $error("range error result is not a single zero-vertex result");

   a_no_stray : assert property (@(posedge clock) disable iff (reset)
      (!busy && !$past(busy)) |-> !rsp_valid)
      else $error("result issued while idle");

endmodule

bind graph_walk_adjacency_matrix gwam_checker u_gwam_checker (.*);
